// ----- rtl/adler32_length_frame_checker_top_macros.svh -----
// Assertion macros shared by the frame checker RTL.
`ifndef ADLER32_LENGTH_FRAME_CHECKER_TOP_MACROS_SVH
`define ADLER32_LENGTH_FRAME_CHECKER_TOP_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ALFC_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define ALFC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/alfc_pkg.sv -----
// Types and constants shared by the length-prefixed Adler-32 frame checker.
package alfc_pkg;

  localparam int unsigned ADLER_MOD       = 65521;
  localparam int unsigned HDR_BYTES       = 4;
  localparam int unsigned LEN_W           = 31;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [LEN_W-1:0] MIN_LEN_RESET  = 31'd10;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET  = 31'd67108864;
  localparam logic [LEN_W-1:0] MIN_BODY_LEN   = 31'd8;
  localparam logic [LEN_W-1:0] NAME_OVERHEAD  = 31'd8;
  localparam logic [LEN_W-1:0] TRAILER_BYTES  = 31'd4;
  localparam logic [31:0]      MIN_NAME_LEN   = 32'd2;
  localparam logic [31:0]      PAYLOAD_OVERHEAD = 32'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_LENGTH   = 2'd1,
    STATUS_BAD_CHECKSUM = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] frame_length;
    logic [31:0] name_length;
    logic [31:0] payload_length;
  } result_t;

  typedef struct packed {
    logic res_valid;
    logic halted;
  } core_stat_t;

endpackage

// ----- rtl/alfc_adler_step.sv -----
// One-byte Adler-32 running sum update with modular correction.
module alfc_adler_step (
  input  logic [15:0] sum_a,
  input  logic [15:0] sum_b,
  input  logic [7:0]  data_byte,
  output logic [15:0] sum_a_nxt,
  output logic [15:0] sum_b_nxt
);

  localparam logic [16:0] Mod = 17'(alfc_pkg::ADLER_MOD);

  logic [16:0] a_raw;
  logic [16:0] b_raw;
  logic [16:0] a_red;
  logic [16:0] b_red;

  assign a_raw     = {1'b0, sum_a} + {9'd0, data_byte};
  assign a_red     = (a_raw >= Mod) ? (a_raw - Mod) : a_raw;
  assign sum_a_nxt = a_red[15:0];
  assign b_raw     = {1'b0, sum_b} + {1'b0, sum_a_nxt};
  assign b_red     = (b_raw >= Mod) ? (b_raw - Mod) : b_raw;
  assign sum_b_nxt = b_red[15:0];

endmodule

// ----- rtl/alfc_frame_core.sv -----
// Frame parser state: header length check, body checksum and end-of-frame verdict.
module alfc_frame_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_valid,
  input  logic [7:0]                  step_byte,
  input  logic [alfc_pkg::LEN_W-1:0]  min_len,
  input  logic [alfc_pkg::LEN_W-1:0]  max_len,
  output alfc_pkg::core_stat_t        stat,
  output alfc_pkg::result_t           res
);

  localparam int unsigned LW = alfc_pkg::LEN_W;

  logic          halted_r,   halted_nxt;
  logic          in_body_r,  in_body_nxt;
  logic [LW-1:0] cnt_r,      cnt_nxt;
  logic [31:0]   len_r,      len_nxt;
  logic [LW-1:0] limit_r,    limit_nxt;
  logic [LW-1:0] last_r,     last_nxt;
  logic [LW-1:0] name_max_r, name_max_nxt;
  logic [31:0]   name_r,     name_nxt;
  logic [15:0]   sum_a_r,    sum_a_nxt;
  logic [15:0]   sum_b_r,    sum_b_nxt;
  logic [31:0]   trailer_r,  trailer_nxt;

  logic [15:0]   step_a;
  logic [15:0]   step_b;
  logic [31:0]   hdr_word;
  logic          hdr_bad;
  logic          name_bad;

  alfc_adler_step u_adler (
    .sum_a     (sum_a_r),
    .sum_b     (sum_b_r),
    .data_byte (step_byte),
    .sum_a_nxt (step_a),
    .sum_b_nxt (step_b)
  );

  assign hdr_word = {len_r[23:0], step_byte};
  assign hdr_bad  = hdr_word[31] || (hdr_word[LW-1:0] > max_len) ||
                    (hdr_word[LW-1:0] < min_len) ||
                    (hdr_word[LW-1:0] < alfc_pkg::MIN_BODY_LEN);
  assign name_bad = name_r[31] || (name_r < alfc_pkg::MIN_NAME_LEN) ||
                    (name_r[LW-1:0] > name_max_r);

  always_comb begin
    halted_nxt   = halted_r;
    in_body_nxt  = in_body_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    limit_nxt    = limit_r;
    last_nxt     = last_r;
    name_max_nxt = name_max_r;
    name_nxt     = name_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    trailer_nxt  = trailer_r;
    stat.halted        = halted_r;
    stat.res_valid     = 1'b0;
    res.status         = alfc_pkg::STATUS_OK;
    res.frame_length   = len_r;
    res.name_length    = 32'd0;
    res.payload_length = 32'd0;
    if (step_valid && !halted_r) begin
      if (!in_body_r) begin
        len_nxt = hdr_word;
        cnt_nxt = cnt_r + LW'(1);
        if (cnt_r[1:0] == 2'(alfc_pkg::HDR_BYTES - 1)) begin
          cnt_nxt = '0;
          if (hdr_bad) begin
            halted_nxt         = 1'b1;
            stat.res_valid     = 1'b1;
            res.status         = alfc_pkg::STATUS_BAD_LENGTH;
            res.frame_length   = hdr_word;
          end else begin
            in_body_nxt  = 1'b1;
            limit_nxt    = hdr_word[LW-1:0] - alfc_pkg::TRAILER_BYTES;
            last_nxt     = hdr_word[LW-1:0] - LW'(1);
            name_max_nxt = hdr_word[LW-1:0] - alfc_pkg::NAME_OVERHEAD;
          end
        end
      end else begin
        if (cnt_r < limit_r) begin
          sum_a_nxt = step_a;
          sum_b_nxt = step_b;
          if (cnt_r < LW'(alfc_pkg::HDR_BYTES)) begin
            name_nxt = {name_r[23:0], step_byte};
          end
        end else begin
          trailer_nxt = {trailer_r[23:0], step_byte};
        end
        cnt_nxt = cnt_r + LW'(1);
        if (cnt_r == last_r) begin
          stat.res_valid = 1'b1;
          if ({sum_b_nxt, sum_a_nxt} != trailer_nxt) begin
            halted_nxt = 1'b1;
            res.status = alfc_pkg::STATUS_BAD_CHECKSUM;
          end else if (name_bad) begin
            halted_nxt      = 1'b1;
            res.status      = alfc_pkg::STATUS_BAD_LENGTH;
            res.name_length = name_r;
          end else begin
            res.name_length    = name_r;
            res.payload_length = len_r - name_r - alfc_pkg::PAYLOAD_OVERHEAD;
            in_body_nxt = 1'b0;
            cnt_nxt     = '0;
            len_nxt     = '0;
            name_nxt    = '0;
            sum_a_nxt   = 16'd1;
            sum_b_nxt   = 16'd0;
            trailer_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r  <= 1'b0;
      in_body_r <= 1'b0;
      cnt_r     <= '0;
      len_r     <= '0;
      name_r    <= '0;
      sum_a_r   <= 16'd1;
      sum_b_r   <= 16'd0;
      trailer_r <= '0;
    end else begin
      halted_r  <= halted_nxt;
      in_body_r <= in_body_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
      name_r    <= name_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      trailer_r <= trailer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r    <= limit_nxt;
    last_r     <= last_nxt;
    name_max_r <= name_max_nxt;
  end

endmodule

// ----- rtl/adler32_length_frame_checker_top.sv -----
// Top level of the length-prefixed frame checker with Adler-32 trailer.
// The in_ channel carries one received stream byte per beat. Each frame is a
// four-byte big-endian body length followed by the body, whose last four bytes
// are the Adler-32 of the body bytes before them.
// The out_ channel carries one status beat per frame: ok with the lengths, an
// invalid frame or name length, or a checksum error. A length error is
// reported on the fourth header byte; otherwise the verdict follows the last
// body byte. After any error the block drops all further bytes until reset.
// The cfg_ channel writes the minimum (index 0) and maximum (index 1) body
// length and is always ready. The user must write it only while the block is
// idle; the block itself does not enforce this.
// A byte passes through an input register and then through combinational
// parsing and checksum logic into the output register of the status beat.
// One byte is accepted every cycle while the output register is free or being
// emptied; a stalled receiver holds the status beat and, once the input
// register is full, holds in_ready low.
// Reset is synchronous, restores the default length limits, clears the valid
// flags of both registers and starts with a fresh header.
module adler32_length_frame_checker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_stream_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [31:0]                out_frame_length,
  output logic signed [31:0]                out_name_length,
  output logic signed [31:0]                out_payload_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [alfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alfc_pkg::LEN_W-1:0]        cfg_data
);

  `include "adler32_length_frame_checker_top_macros.svh"

  logic                       in_valid_r, in_valid_nxt;
  logic [7:0]                 in_byte_r;
  logic                       out_valid_r, out_valid_nxt;
  alfc_pkg::result_t          out_res_r;
  logic [alfc_pkg::LEN_W-1:0] min_len_r;
  logic [alfc_pkg::LEN_W-1:0] max_len_r;
  logic                       advance;
  logic                       step_valid;
  alfc_pkg::core_stat_t       core_stat;
  alfc_pkg::result_t          core_res;

  assign advance    = !out_valid_r || out_ready;
  assign step_valid = in_valid_r && advance;
  assign in_ready   = !in_valid_r || advance;
  assign cfg_ready  = 1'b1;

  alfc_frame_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .step_byte  (in_byte_r),
    .min_len    (min_len_r),
    .max_len    (max_len_r),
    .stat       (core_stat),
    .res        (core_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step_valid) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = core_stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      min_len_r   <= alfc_pkg::MIN_LEN_RESET;
      max_len_r   <= alfc_pkg::MAX_LEN_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          alfc_pkg::CFG_MIN_LEN: min_len_r <= cfg_data;
          alfc_pkg::CFG_MAX_LEN: max_len_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_stream_byte;
    end
    if (advance && core_stat.res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_frame_length   = out_res_r.frame_length;
  assign out_name_length    = out_res_r.name_length;
  assign out_payload_length = out_res_r.payload_length;

  `ALFC_ASSERT_SAME(a_halted_silent, core_stat.halted, !core_stat.res_valid, "result after halt")
  `ALFC_ASSERT_NEXT(a_error_halts,
    core_stat.res_valid && (core_res.status != alfc_pkg::STATUS_OK), core_stat.halted,
    "error result did not halt the parser")
  `ALFC_ASSERT_NEXT(a_input_held, in_valid_r && !advance,
    in_valid_r && $stable(in_byte_r), "buffered byte lost while stalled")
  `ALFC_ASSERT_SAME(a_no_step_on_stall, out_valid_r && !out_ready, !step_valid,
    "byte processed while result register full")

endmodule
